// ----- rtl/gso3_pkg.sv -----
// Shared widths, types and constants for the 3x3 Gram-Schmidt orthonormalizer.
// No dependencies; every other file of the block depends on this package.
package gso3_pkg;

   localparam int ELEM_WIDTH_DEF = 16;   // default input element width
   localparam int MAG_W          = 30;   // block-scaled magnitude, top bit at 29
   localparam int C_W            = 31;   // signed block-scaled column element
   localparam int U_W            = 32;   // signed Q.30 unit vector element
   localparam int V_W            = 64;   // signed residual element
   localparam int SQ_W           = 62;   // sum of three squared magnitudes
   localparam int D_W            = 33;   // signed projection coefficient
   localparam int UNIT_FRAC      = 30;   // fraction bits of a unit element
   localparam int TOL_LOG2       = 44;   // residual below 2^44 counts as zero
   localparam int OUT_W          = 16;   // Q1.14 result element
   localparam int OUT_SHIFT      = 16;   // Q.30 to Q1.14
   localparam int OUT_MAX        = 16384;

   typedef logic [MAG_W-1:0]        mag_type;
   typedef mag_type [2:0]           mag3_type;
   typedef logic signed [C_W-1:0]   col_type;
   typedef col_type [2:0]           col3_type;
   typedef logic signed [U_W-1:0]   unit_type;
   typedef unit_type [2:0]          unit3_type;
   typedef logic signed [V_W-1:0]   vec_type;
   typedef vec_type [2:0]           vec3_type;

   // per-stage status that travels with the data
   typedef struct packed {
      logic valid;
      logic zero;
   } stat_type;

endpackage

// ----- rtl/gso3_ifs.sv -----
// Request and response stream interfaces of the 3x3 orthonormalizer.
// Depends on gso3_pkg for the default element width.
interface gso3_req_if #(parameter int ELEM_WIDTH = gso3_pkg::ELEM_WIDTH_DEF) ();
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                 output ready);
endinterface

interface gso3_rsp_if ();
   logic              valid;
   logic              ready;
   logic signed [15:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;
   logic              degenerate;
   modport source (output valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                   degenerate, input ready);
   modport sink (input valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                 degenerate, output ready);
endinterface

// ----- rtl/gso3_bscale.sv -----
// Two-stage block scaler: magnitudes and signs, then a common shift that puts
// the largest magnitude in [2^29, 2^30). Depends on gso3_pkg.
module gso3_bscale #(
   parameter int VW = gso3_pkg::C_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0][VW-1:0]   vec_in,
   output gso3_pkg::mag3_type   mag_out,
   output logic [2:0]           neg_out,
   output gso3_pkg::stat_type   stat_out
);
   import gso3_pkg::*;

   localparam int XW  = VW + MAG_W;
   localparam int TOP = MAG_W - 1;

   logic [2:0][VW-1:0] abs_in, abs_ff;
   logic [2:0]         neg1_ff, neg2_ff;
   logic               valid1_ff;
   logic [VW-1:0]      lead;
   int                 msb;
   logic [XW-1:0]      ext;
   mag3_type           mag_in, mag_ff;
   stat_type           stat_in, stat_ff;

   // stage 1: absolute values
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = vec_in[i][VW-1] ? (~vec_in[i] + VW'(1)) : vec_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         abs_ff  <= abs_in;
         neg1_ff <= {vec_in[2][VW-1], vec_in[1][VW-1], vec_in[0][VW-1]};
      end
   end

   // stage 2: leading one of the OR of magnitudes sets the common shift
   always_comb begin
      lead = abs_ff[0] | abs_ff[1] | abs_ff[2];
      msb  = 0;
      for (int b = 0; b < VW; b++) begin
         if (lead[b]) msb = b;
      end
      for (int i = 0; i < 3; i++) begin
         ext = XW'(abs_ff[i]);
         if (msb >= TOP) begin
            ext = ext >> (msb - TOP);
         end else begin
            ext = ext << (TOP - msb);
         end
         mag_in[i] = ext[MAG_W-1:0];
      end
      stat_in.valid = valid1_ff;
      stat_in.zero  = (lead == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else if (en) begin
         stat_ff <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg2_ff <= neg1_ff;
      end
   end

   assign mag_out  = mag_ff;
   assign neg_out  = neg2_ff;
   assign stat_out = stat_ff;

endmodule

// ----- rtl/gso3_norm.sv -----
// Pipelined unit-vector unit: block scale, sum of squares, one root bit per
// stage, then three restoring dividers with one quotient bit per stage.
// Depends on gso3_pkg and gso3_bscale.
module gso3_norm #(
   parameter int VW     = gso3_pkg::V_W,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0][VW-1:0]   vec_in,
   input  logic [SIDE_W-1:0]    side_in,
   output gso3_pkg::unit3_type  u_out,
   output gso3_pkg::stat_type   stat_out,
   output logic [SIDE_W-1:0]    side_out
);
   import gso3_pkg::*;

   localparam int STEPS  = SQ_W / 2;            // root bits, also quotient bits
   localparam int REM_W  = STEPS + 3;
   localparam int NUM_W  = MAG_W + UNIT_FRAC + 1;
   localparam int DREM_W = STEPS + 1;

   mag3_type            bs_mag;
   logic [2:0]          bs_neg;
   stat_type            bs_stat;
   logic [SIDE_W-1:0]   side_a_ff, side_b_ff;

   gso3_bscale #(.VW(VW)) u_bscale (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_valid),
      .vec_in   (vec_in),
      .mag_out  (bs_mag),
      .neg_out  (bs_neg),
      .stat_out (bs_stat)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff <= side_in;
         side_b_ff <= side_a_ff;
      end
   end

   // squares of the scaled magnitudes
   logic [2*MAG_W-1:0]  sq_ff [3];
   mag3_type            sq_mag_ff;
   logic [2:0]          sq_neg_ff;
   stat_type            sq_stat_ff;
   logic [SIDE_W-1:0]   sq_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_stat_ff <= '0;
      end else if (en) begin
         sq_stat_ff <= bs_stat;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= (2*MAG_W)'(bs_mag[i]) * (2*MAG_W)'(bs_mag[i]);
         end
         sq_mag_ff  <= bs_mag;
         sq_neg_ff  <= bs_neg;
         sq_side_ff <= side_b_ff;
      end
   end

   // square root, stage 0 holds the sum
   logic [SQ_W-1:0]     rt_s_ff    [STEPS+1];
   logic [STEPS-1:0]    rt_root_ff [STEPS+1];
   logic [REM_W-1:0]    rt_rem_ff  [STEPS+1];
   mag3_type            rt_mag_ff  [STEPS+1];
   logic [2:0]          rt_neg_ff  [STEPS+1];
   stat_type            rt_stat_ff [STEPS+1];
   logic [SIDE_W-1:0]   rt_side_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_stat_ff[0] <= '0;
      end else if (en) begin
         rt_stat_ff[0] <= sq_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_s_ff[0]    <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
         rt_root_ff[0] <= '0;
         rt_rem_ff[0]  <= '0;
         rt_mag_ff[0]  <= sq_mag_ff;
         rt_neg_ff[0]  <= sq_neg_ff;
         rt_side_ff[0] <= sq_side_ff;
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_root
      logic [REM_W-1:0] cat, trial, rem_in;
      logic [STEPS-1:0] root_in;

      // bring down the next two bits of the sum and try a 1 root bit
      assign cat   = {rt_rem_ff[j][REM_W-3:0], rt_s_ff[j][2*(STEPS-1-j)+1 -: 2]};
      assign trial = REM_W'({rt_root_ff[j], 2'b01});

      always_comb begin
         if (cat >= trial) begin
            rem_in  = cat - trial;
            root_in = {rt_root_ff[j][STEPS-2:0], 1'b1};
         end else begin
            rem_in  = cat;
            root_in = {rt_root_ff[j][STEPS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_stat_ff[j+1] <= '0;
         end else if (en) begin
            rt_stat_ff[j+1] <= rt_stat_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_s_ff[j+1]    <= rt_s_ff[j];
            rt_root_ff[j+1] <= root_in;
            rt_rem_ff[j+1]  <= rem_in;
            rt_mag_ff[j+1]  <= rt_mag_ff[j];
            rt_neg_ff[j+1]  <= rt_neg_ff[j];
            rt_side_ff[j+1] <= rt_side_ff[j];
         end
      end
   end

   // dividers: (a * 2^30 + r/2) / r for each element
   logic [2:0][DREM_W-1:0] dv_rem_ff  [STEPS+1];
   logic [2:0][STEPS-1:0]  dv_low_ff  [STEPS+1];
   logic [2:0][STEPS-1:0]  dv_q_ff    [STEPS+1];
   logic [STEPS-1:0]       dv_r_ff    [STEPS+1];
   logic [2:0]             dv_neg_ff  [STEPS+1];
   stat_type               dv_stat_ff [STEPS+1];
   logic [SIDE_W-1:0]      dv_side_ff [STEPS+1];
   logic [NUM_W-1:0]       num_in     [3];
   logic [STEPS-1:0]       root_fin;

   assign root_fin = rt_root_ff[STEPS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = NUM_W'({rt_mag_ff[STEPS][i], UNIT_FRAC'(0)}) + NUM_W'(root_fin >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_stat_ff[0] <= '0;
      end else if (en) begin
         dv_stat_ff[0] <= rt_stat_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= DREM_W'(num_in[i][NUM_W-1:STEPS]);
            dv_low_ff[0][i] <= num_in[i][STEPS-1:0];
            dv_q_ff[0][i]   <= '0;
         end
         dv_r_ff[0]    <= root_fin;
         dv_neg_ff[0]  <= rt_neg_ff[STEPS];
         dv_side_ff[0] <= rt_side_ff[STEPS];
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_div
      logic [2:0][DREM_W-1:0] cat;
      logic [2:0][DREM_W-1:0] rem_in;
      logic [2:0][STEPS-1:0]  q_in;

      // one quotient bit per element
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            cat[i] = {dv_rem_ff[j][i][DREM_W-2:0], dv_low_ff[j][i][STEPS-1-j]};
            if (cat[i] >= DREM_W'(dv_r_ff[j])) begin
               rem_in[i] = cat[i] - DREM_W'(dv_r_ff[j]);
               q_in[i]   = {dv_q_ff[j][i][STEPS-2:0], 1'b1};
            end else begin
               rem_in[i] = cat[i];
               q_in[i]   = {dv_q_ff[j][i][STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_stat_ff[j+1] <= '0;
         end else if (en) begin
            dv_stat_ff[j+1] <= dv_stat_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j+1]  <= rem_in;
            dv_low_ff[j+1]  <= dv_low_ff[j];
            dv_q_ff[j+1]    <= q_in;
            dv_r_ff[j+1]    <= dv_r_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   // apply signs; a zero vector gives a zero result
   unit3_type          u_in, u_ff;
   stat_type           stat_ff;
   logic [SIDE_W-1:0]  side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_stat_ff[STEPS].zero) begin
            u_in[i] = '0;
         end else if (dv_neg_ff[STEPS][i]) begin
            u_in[i] = -U_W'(dv_q_ff[STEPS][i]);
         end else begin
            u_in[i] = U_W'(dv_q_ff[STEPS][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else if (en) begin
         stat_ff <= dv_stat_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= u_in;
         side_ff <= dv_side_ff[STEPS];
      end
   end

   assign u_out    = u_ff;
   assign stat_out = stat_ff;
   assign side_out = side_ff;

endmodule

// ----- rtl/gso3_proj.sv -----
// Four-stage projection remover: v = c*2^30 - d0*b0 - d1*b1, with d rounded
// dot products, and a flag for a residual below tolerance. Depends on gso3_pkg.
module gso3_proj #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  gso3_pkg::col3_type   c_in,
   input  gso3_pkg::unit3_type  b0_in,
   input  gso3_pkg::unit3_type  b1_in,
   input  logic [SIDE_W-1:0]    side_in,
   output gso3_pkg::vec3_type   v_out,
   output gso3_pkg::stat_type   stat_out,
   output logic [SIDE_W-1:0]    side_out
);
   import gso3_pkg::*;

   localparam int P_W = U_W + C_W;

   logic [3:0]         valid_ff;
   col3_type           c_ff   [3];
   unit3_type          b0_ff  [3];
   unit3_type          b1_ff  [3];
   logic [SIDE_W-1:0]  side_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff[0]    <= c_in;
         b0_ff[0]   <= b0_in;
         b1_ff[0]   <= b1_in;
         side_ff[0] <= side_in;
         for (int s = 1; s < 3; s++) begin
            c_ff[s]  <= c_ff[s-1];
            b0_ff[s] <= b0_ff[s-1];
            b1_ff[s] <= b1_ff[s-1];
         end
         for (int s = 1; s < 4; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // stage 1: element products of the dot products
   logic signed [P_W-1:0] p0_ff [3];
   logic signed [P_W-1:0] p1_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p0_ff[i] <= $signed(b0_in[i]) * $signed(c_in[i]);
            p1_ff[i] <= $signed(b1_in[i]) * $signed(c_in[i]);
         end
      end
   end

   // stage 2: sums rounded from Q.30, half away from zero
   logic signed [V_W-1:0] sum0, sum1;
   logic [V_W-1:0]        mag0, mag1, rq0, rq1;
   logic signed [D_W-1:0] d0_in, d1_in, d0_ff, d1_ff;

   always_comb begin
      sum0  = V_W'(p0_ff[0]) + V_W'(p0_ff[1]) + V_W'(p0_ff[2]);
      sum1  = V_W'(p1_ff[0]) + V_W'(p1_ff[1]) + V_W'(p1_ff[2]);
      mag0  = sum0[V_W-1] ? -sum0 : sum0;
      mag1  = sum1[V_W-1] ? -sum1 : sum1;
      rq0   = (mag0 + (V_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      rq1   = (mag1 + (V_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
      d0_in = sum0[V_W-1] ? -D_W'(rq0) : D_W'(rq0);
      d1_in = sum1[V_W-1] ? -D_W'(rq1) : D_W'(rq1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
      end
   end

   // stage 3: projection terms
   vec_type e0_ff [3];
   vec_type e1_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e0_ff[i] <= d0_ff * $signed(b0_ff[1][i]);
            e1_ff[i] <= d1_ff * $signed(b1_ff[1][i]);
         end
      end
   end

   // stage 4: residual and tolerance test
   vec3_type  v_in, v_ff;
   logic      small_in, small_ff;

   always_comb begin
      small_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         v_in[i] = (V_W'(c_ff[2][i]) <<< UNIT_FRAC) - e0_ff[i] - e1_ff[i];
         if (v_in[i][V_W-1]) begin
            if (!(&v_in[i][V_W-1:TOL_LOG2]) || (v_in[i][TOL_LOG2-1:0] == '0)) begin
               small_in = 1'b0;
            end
         end else if (v_in[i][V_W-1:TOL_LOG2] != '0) begin
            small_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff     <= v_in;
         small_ff <= small_in;
      end
   end

   assign v_out          = v_ff;
   assign stat_out.valid = valid_ff[3];
   assign stat_out.zero  = small_ff;
   assign side_out       = side_ff[3];

endmodule

// ----- rtl/gram_schmidt_orthonormalize_3x3.sv -----
// Gram-Schmidt orthonormalizer for one 3x3 matrix per request.
// req_if (sink): nine signed elements a00..a22, row-major, ELEM_WIDTH bits.
// rsp_if (source): the orthonormal columns q00..q22 in Q1.14 plus degenerate.
// A request is accepted when valid and ready are both high; one response per
// request, in order. The pipeline takes one request every cycle while no
// response is held. In order it holds the column scalers, one unit-vector
// unit per column (one root bit and one quotient bit per stage, 31 stages
// each), projection removers before the last two, and the output register.
// A stalled receiver freezes the whole pipeline; req_if.ready is high while
// the output register is empty or being taken, so nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; no response is
// pending afterwards. A column with no remaining length zeroes itself and the
// following columns and raises degenerate.
// Depends on gso3_pkg, gso3_ifs, gso3_bscale, gso3_norm and gso3_proj.
module gram_schmidt_orthonormalize_3x3 #(
   parameter int ELEM_WIDTH = gso3_pkg::ELEM_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gso3_req_if.sink    req_if,
   gso3_rsp_if.source  rsp_if
);
   import gso3_pkg::*;

   typedef struct packed {
      col3_type c1;
      col3_type c2;
   } s0_type;

   typedef struct packed {
      col3_type  c2;
      unit3_type u0;
      logic      deg0;
   } s1_type;

   typedef struct packed {
      col3_type  c2;
      unit3_type u0;
      logic      deg0;
      logic      deg1;
   } s2_type;

   typedef struct packed {
      unit3_type u0;
      unit3_type u1;
      logic      deg0;
      logic      deg1;
   } s3_type;

   typedef struct packed {
      unit3_type u0;
      unit3_type u1;
      logic      deg0;
      logic      deg1;
      logic      deg2;
   } s4_type;

   function automatic logic signed [OUT_W-1:0] to_out(unit_type u);
      logic [U_W-1:0] m;
      logic [U_W-1:0] r;
      m = u[U_W-1] ? -u : u;
      r = (m + (U_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      if (r > U_W'(OUT_MAX)) r = U_W'(OUT_MAX);
      return u[U_W-1] ? -OUT_W'(r) : OUT_W'(r);
   endfunction

   logic pipe_en;
   logic rsp_valid_ff;

   // whole pipeline advances unless a response is held
   assign pipe_en      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = pipe_en;

   // scale each input column
   logic [2:0][ELEM_WIDTH-1:0] fcol [3];
   mag3_type                   f_mag  [3];
   logic [2:0]                 f_neg  [3];
   stat_type                   f_stat [3];
   col3_type                   c_col  [3];

   assign fcol[0] = {req_if.a20, req_if.a10, req_if.a00};
   assign fcol[1] = {req_if.a21, req_if.a11, req_if.a01};
   assign fcol[2] = {req_if.a22, req_if.a12, req_if.a02};

   for (genvar j = 0; j < 3; j++) begin : g_front
      gso3_bscale #(.VW(ELEM_WIDTH)) u_front (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .in_valid (req_if.valid),
         .vec_in   (fcol[j]),
         .mag_out  (f_mag[j]),
         .neg_out  (f_neg[j]),
         .stat_out (f_stat[j])
      );
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            c_col[j][i] = f_neg[j][i] ? -C_W'(f_mag[j][i]) : C_W'(f_mag[j][i]);
         end
      end
   end

   // column 0
   s0_type     n0_side_in, n0_side;
   unit3_type  u0;
   stat_type   n0_stat;

   assign n0_side_in.c1 = c_col[1];
   assign n0_side_in.c2 = c_col[2];

   gso3_norm #(.VW(C_W), .SIDE_W($bits(s0_type))) u_norm0 (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (f_stat[0].valid && f_stat[1].valid && f_stat[2].valid),
      .vec_in   (c_col[0]),
      .side_in  (n0_side_in),
      .u_out    (u0),
      .stat_out (n0_stat),
      .side_out (n0_side)
   );

   // column 1: remove projection on q0
   s1_type     p1_side_in, p1_side;
   vec3_type   v1;
   stat_type   p1_stat;

   assign p1_side_in.c2   = n0_side.c2;
   assign p1_side_in.u0   = u0;
   assign p1_side_in.deg0 = n0_stat.zero;

   gso3_proj #(.SIDE_W($bits(s1_type))) u_proj1 (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (n0_stat.valid),
      .c_in     (n0_side.c1),
      .b0_in    (u0),
      .b1_in    ('0),
      .side_in  (p1_side_in),
      .v_out    (v1),
      .stat_out (p1_stat),
      .side_out (p1_side)
   );

   s2_type     n1_side_in, n1_side;
   unit3_type  u1;
   stat_type   n1_stat;

   assign n1_side_in.c2   = p1_side.c2;
   assign n1_side_in.u0   = p1_side.u0;
   assign n1_side_in.deg0 = p1_side.deg0;
   assign n1_side_in.deg1 = p1_side.deg0 || p1_stat.zero;

   gso3_norm #(.VW(V_W), .SIDE_W($bits(s2_type))) u_norm1 (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (p1_stat.valid),
      .vec_in   (v1),
      .side_in  (n1_side_in),
      .u_out    (u1),
      .stat_out (n1_stat),
      .side_out (n1_side)
   );

   // column 2: remove projections on q0 and q1
   s3_type     p2_side_in, p2_side;
   vec3_type   v2;
   stat_type   p2_stat;

   assign p2_side_in.u0   = n1_side.u0;
   assign p2_side_in.u1   = u1;
   assign p2_side_in.deg0 = n1_side.deg0;
   assign p2_side_in.deg1 = n1_side.deg1 || n1_stat.zero;

   gso3_proj #(.SIDE_W($bits(s3_type))) u_proj2 (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (n1_stat.valid),
      .c_in     (n1_side.c2),
      .b0_in    (n1_side.u0),
      .b1_in    (u1),
      .side_in  (p2_side_in),
      .v_out    (v2),
      .stat_out (p2_stat),
      .side_out (p2_side)
   );

   s4_type     n2_side_in, n2_side;
   unit3_type  u2;
   stat_type   n2_stat;

   assign n2_side_in.u0   = p2_side.u0;
   assign n2_side_in.u1   = p2_side.u1;
   assign n2_side_in.deg0 = p2_side.deg0;
   assign n2_side_in.deg1 = p2_side.deg1;
   assign n2_side_in.deg2 = p2_side.deg1 || p2_stat.zero;

   gso3_norm #(.VW(V_W), .SIDE_W($bits(s4_type))) u_norm2 (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (p2_stat.valid),
      .vec_in   (v2),
      .side_in  (n2_side_in),
      .u_out    (u2),
      .stat_out (n2_stat),
      .side_out (n2_side)
   );

   // output register: mask degenerate columns, round to Q1.14
   logic signed [OUT_W-1:0] q_in [3][3];
   logic signed [OUT_W-1:0] q_ff [3][3];
   logic                    deg_in, deg_ff;

   always_comb begin
      deg_in = n2_side.deg2 || n2_stat.zero;
      for (int i = 0; i < 3; i++) begin
         q_in[i][0] = n2_side.deg0 ? '0 : to_out(n2_side.u0[i]);
         q_in[i][1] = n2_side.deg1 ? '0 : to_out(n2_side.u1[i]);
         q_in[i][2] = deg_in       ? '0 : to_out(u2[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= n2_stat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         q_ff   <= q_in;
         deg_ff <= deg_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.q00        = q_ff[0][0];
   assign rsp_if.q01        = q_ff[0][1];
   assign rsp_if.q02        = q_ff[0][2];
   assign rsp_if.q10        = q_ff[1][0];
   assign rsp_if.q11        = q_ff[1][1];
   assign rsp_if.q12        = q_ff[1][2];
   assign rsp_if.q20        = q_ff[2][0];
   assign rsp_if.q21        = q_ff[2][1];
   assign rsp_if.q22        = q_ff[2][2];
   assign rsp_if.degenerate = deg_ff;

`ifndef SYNTH
   // a degenerate matrix always has a zero last column
   a_deg_col2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && deg_ff |-> q_ff[0][2] == 0 && q_ff[1][2] == 0 && q_ff[2][2] == 0)
      else $error("degenerate response with nonzero last column");

   // a zero first column can only come from a degenerate matrix
   a_col0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && q_ff[0][0] == 0 && q_ff[1][0] == 0 && q_ff[2][0] == 0 |-> deg_ff)
      else $error("zero first column without degenerate flag");

   // the diagonal elements q00 and q11 stay within one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> q_ff[0][0] <= OUT_MAX && q_ff[0][0] >= -OUT_MAX &&
                       q_ff[1][1] <= OUT_MAX && q_ff[1][1] >= -OUT_MAX)
      else $error("response element out of range");

   // a held response freezes the last pipeline stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> $stable(n2_stat.valid) && rsp_valid_ff)
      else $error("pipeline moved while response was stalled");
`endif

endmodule

// ----- tb/gram_schmidt_orthonormalize_3x3_tb.sv -----
// Self-checking testbench for the 3x3 Gram-Schmidt orthonormalizer.
// Depends on gso3_pkg, gso3_ifs and the gram_schmidt_orthonormalize_3x3 RTL.
module gram_schmidt_orthonormalize_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gso3_pkg::*;

   localparam int EW          = ELEM_WIDTH_DEF;
   localparam int DRAIN_WAIT  = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 700;
   localparam longint unsigned SCALE_LO = 64'd1 << 29;
   localparam longint unsigned SCALE_HI = 64'd1 << 30;

   typedef struct {
      logic signed [EW-1:0] a[9];
   } matrix_type;

   typedef struct {
      logic signed [OUT_W-1:0] q[9];
      logic                    degen;
   } ortho_type;

   logic clock = 1'b0;
   logic reset;

   gso3_req_if #(.ELEM_WIDTH(EW)) req_if ();
   gso3_rsp_if rsp_if ();

   gram_schmidt_orthonormalize_3x3 #(.ELEM_WIDTH(EW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   ortho_type expected_q[$];
   int     fail_cnt   = 0;
   int     sent_cnt   = 0;
   int     rcvd_cnt   = 0;
   int     degen_cnt  = 0;
   int     idle_pct   = 0;
   int     stall_pct  = 0;
   int     hold_cnt   = 0;
   int     cycle_cnt  = 0;

   // ---------------- predictor ----------------
   function automatic longint unsigned mag_of(longint x);
      return x < 0 ? longint'(0) - x : x;
   endfunction

   function automatic longint with_sign(longint unsigned m, bit ng);
      return ng ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s   = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // shift a vector until its largest magnitude sits in [2^29, 2^30)
   function automatic bit norm_scale(input longint v[3], output longint unsigned m[3],
                                     output bit ng[3]);
      longint unsigned mx;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i]  = mag_of(v[i]);
         ng[i] = v[i] < 0;
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 1'b0;
      while (mx >= SCALE_HI) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < SCALE_LO) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      return 1'b1;
   endfunction

   function automatic void unit_of(input longint unsigned m[3], input bit ng[3],
                                   output longint u[3]);
      longint unsigned r;
      r = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) u[i] = with_sign(((m[i] << 30) + (r >> 1)) / r, ng[i]);
   endfunction

   function automatic longint round_unit(longint x);
      return with_sign((mag_of(x) + (64'd1 << 29)) >> 30, x < 0);
   endfunction

   function automatic bit below_tol(longint v[3]);
      longint unsigned tol;
      tol = 64'd1 << TOL_LOG2;
      return mag_of(v[0]) < tol && mag_of(v[1]) < tol && mag_of(v[2]) < tol;
   endfunction

   function automatic logic signed [OUT_W-1:0] to_q14(longint u);
      longint q;
      q = with_sign((mag_of(u) + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT, u < 0);
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < -OUT_MAX) q = -OUT_MAX;
      return q[OUT_W-1:0];
   endfunction

   function automatic ortho_type orthonormalize(matrix_type mx);
      longint          col[3][3], c[3][3], u[3][3], v[3];
      longint unsigned m[3];
      bit              ng[3];
      bit              degen;
      longint          d0, d1;
      ortho_type       res;
      degen = 1'b0;
      for (int j = 0; j < 3; j++)
         for (int i = 0; i < 3; i++) u[j][i] = 0;
      // scale each input column on its own
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) col[j][i] = mx.a[i*3+j];
         if (norm_scale(col[j], m, ng)) begin
            for (int i = 0; i < 3; i++) c[j][i] = with_sign(m[i], ng[i]);
         end else begin
            for (int i = 0; i < 3; i++) c[j][i] = 0;
         end
      end
      if (!norm_scale(c[0], m, ng)) degen = 1'b1;
      else unit_of(m, ng, u[0]);
      // second column minus its projection on q0
      if (!degen) begin
         d0 = round_unit(u[0][0]*c[1][0] + u[0][1]*c[1][1] + u[0][2]*c[1][2]);
         for (int i = 0; i < 3; i++) v[i] = c[1][i] * (64'sd1 << 30) - d0 * u[0][i];
         if (below_tol(v) || !norm_scale(v, m, ng)) degen = 1'b1;
         else unit_of(m, ng, u[1]);
      end
      // third column, both coefficients against the original column
      if (!degen) begin
         d0 = round_unit(u[0][0]*c[2][0] + u[0][1]*c[2][1] + u[0][2]*c[2][2]);
         d1 = round_unit(u[1][0]*c[2][0] + u[1][1]*c[2][1] + u[1][2]*c[2][2]);
         for (int i = 0; i < 3; i++)
            v[i] = c[2][i] * (64'sd1 << 30) - d0 * u[0][i] - d1 * u[1][i];
         if (below_tol(v) || !norm_scale(v, m, ng)) degen = 1'b1;
         else unit_of(m, ng, u[2]);
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) res.q[i*3+j] = to_q14(u[j][i]);
      res.degen = degen;
      return res;
   endfunction

   // ---------------- request driver ----------------
   task automatic send_matrix(matrix_type mx);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.a00 <= mx.a[0]; req_if.a01 <= mx.a[1]; req_if.a02 <= mx.a[2];
      req_if.a10 <= mx.a[3]; req_if.a11 <= mx.a[4]; req_if.a12 <= mx.a[5];
      req_if.a20 <= mx.a[6]; req_if.a21 <= mx.a[7]; req_if.a22 <= mx.a[8];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_q.push_back(orthonormalize(mx));
      sent_cnt++;
   endtask

   function automatic matrix_type make_matrix(int v0, int v1, int v2, int v3, int v4,
                                              int v5, int v6, int v7, int v8);
      matrix_type mx;
      mx.a[0] = EW'(v0); mx.a[1] = EW'(v1); mx.a[2] = EW'(v2);
      mx.a[3] = EW'(v3); mx.a[4] = EW'(v4); mx.a[5] = EW'(v5);
      mx.a[6] = EW'(v6); mx.a[7] = EW'(v7); mx.a[8] = EW'(v8);
      return mx;
   endfunction

   // random matrix, mostly well-conditioned with some rank-deficient shapes
   function automatic matrix_type rand_matrix();
      matrix_type mx;
      int         kind, k, zc;
      kind = $urandom_range(9);
      for (int n = 0; n < 9; n++) mx.a[n] = EW'($urandom);
      case (kind)
         6: begin
            for (int n = 0; n < 9; n++) mx.a[n] = EW'(int'($urandom_range(16)) - 8);
         end
         7: begin
            k = int'($urandom_range(16)) - 8;
            for (int i = 0; i < 3; i++) begin
               mx.a[i*3]   = EW'(int'($urandom_range(2000)) - 1000);
               mx.a[i*3+1] = EW'(int'(mx.a[i*3]) * k);
            end
         end
         8: begin
            for (int i = 0; i < 3; i++) begin
               mx.a[i*3]   = EW'(int'($urandom_range(2000)) - 1000);
               mx.a[i*3+1] = EW'(int'($urandom_range(2000)) - 1000);
               mx.a[i*3+2] = mx.a[i*3] - mx.a[i*3+1];
            end
         end
         9: begin
            zc = $urandom_range(2);
            for (int i = 0; i < 3; i++) mx.a[i*3+zc] = '0;
         end
         default: ;
      endcase
      return mx;
   endfunction

   // ---------------- response side ----------------
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      ortho_type got, exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.q[0] = rsp_if.q00; got.q[1] = rsp_if.q01; got.q[2] = rsp_if.q02;
         got.q[3] = rsp_if.q10; got.q[4] = rsp_if.q11; got.q[5] = rsp_if.q12;
         got.q[6] = rsp_if.q20; got.q[7] = rsp_if.q21; got.q[8] = rsp_if.q22;
         got.degen = rsp_if.degenerate;
         rcvd_cnt++;
         if (expected_q.size() == 0) begin
            fail_cnt++;
            $display("%0t: response with no request outstanding", $time);
         end else begin
            exp_r = expected_q.pop_front();
            if (exp_r.degen) degen_cnt++;
            for (int n = 0; n < 9; n++)
               if (got.q[n] !== exp_r.q[n]) begin
                  fail_cnt++;
                  if (fail_cnt <= 50)
                     $display("%0t: q%0d%0d expected %0d actual %0d", $time, n / 3, n % 3,
                              exp_r.q[n], got.q[n]);
               end
            if (got.degen !== exp_r.degen) begin
               fail_cnt++;
               if (fail_cnt <= 50)
                  $display("%0t: degenerate expected %0b actual %0b", $time,
                           exp_r.degen, got.degen);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_extremes();
      send_matrix(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
      send_matrix(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
      send_matrix(make_matrix(32767, -32768, 32767, -32768, 32767, -32768,
                              32767, 32767, -32768));
      send_matrix(make_matrix(-32768, -32768, -32768, -32768, 32767, 32767,
                              -32768, -32768, 32767));
      send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(make_matrix(-1, 1, -1, 1, 1, 1, 1, -1, -1));
      send_matrix(make_matrix(4096, 1, 0, 1, 4096, 1, 0, 1, 4096));
      send_matrix(make_matrix(0, 0, 1, 0, 1, 0, 1, 0, 0));
      send_matrix(make_matrix(3, 1, 2, -5, 7, 1, 9, -2, 4));
      send_matrix(make_matrix(32767, 32766, 1, 32767, 32767, -1, 32767, 32767, 0));
   endtask

   // zero matrix and zero columns, parallel second column, third column in the span
   task automatic test_degenerate();
      send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_matrix(make_matrix(0, 5, 1, 0, 3, 2, 0, -7, 9));
      send_matrix(make_matrix(5, 0, 1, 3, 0, 2, -7, 0, 9));
      send_matrix(make_matrix(2, 4, 1, -3, -6, 2, 1, 2, 9));
      send_matrix(make_matrix(-32768, 32767, 5, -32768, 32767, 6, -32768, 32767, 7));
      send_matrix(make_matrix(1, 2, 3, 4, 5, 9, 7, 8, 15));
      send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 0));
      send_matrix(make_matrix(100, 200, 300, 0, 0, 0, 0, 0, 0));
      send_matrix(make_matrix(1, 1, 0, 1, 1, 0, 0, 0, 1));
      send_matrix(make_matrix(32767, 1, 0, 32767, 1, 0, 32767, 1, 1));
   endtask

   task automatic test_random_phases();
      int phase_idle[4]  = '{0, 66, 0, 14};
      int phase_stall[4] = '{0, 0, 66, 14};
      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < 100; n++) send_matrix(rand_matrix());
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_cnt  = HOLD_LEN;
      for (int n = 0; n < 300; n++) send_matrix(rand_matrix());
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.a00 = '0; req_if.a01 = '0; req_if.a02 = '0;
      req_if.a10 = '0; req_if.a11 = '0; req_if.a12 = '0;
      req_if.a20 = '0; req_if.a21 = '0; req_if.a22 = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_degenerate();
      test_random_phases();
      test_backpressure();
      req_if.valid <= 1'b0;

      // drain
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      fail_cnt += expected_q.size();

      $display("Sent %0d matrices, checked %0d results (%0d degenerate),", sent_cnt,
               rcvd_cnt, degen_cnt);
      $display("across idle, stall and long hold-off phases; %0d mismatches.", fail_cnt);
      if (fail_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
